// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

  // Default number of entries in the ring store
  localparam int DEQ_CAPACITY = 16;

  // Payload widths fixed by the interface
  localparam int ValueW    = 32;
  localparam int ActionW   = 2;
  localparam int StatusW   = 2;
  localparam int CountOutW = 5;

  // Action codes
  localparam logic [ActionW-1:0] ACT_PUSH_LEFT  = 2'd0;
  localparam logic [ActionW-1:0] ACT_PUSH_RIGHT = 2'd1;
  localparam logic [ActionW-1:0] ACT_POP_LEFT   = 2'd2;
  localparam logic [ActionW-1:0] ACT_POP_RIGHT  = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] STAT_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STAT_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;     // run the accepted action this cycle
    logic respond;  // present the result this cycle
  } deq_cmd_t;

endpackage

// ===== design/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Channel   Transfer when          Signals
// --------  ---------------------  ------------------------------------------
// command   start & !busy          action_i, value_i
// result    done_o (one cycle)     status_o, removed_value_o, count_o
//
// Each command runs its action in the cycle it is taken
// (pointer update and ring store access); the result shows in the next one
// with the registered read data of the store. busy is high in that cycle.
// Reset clears pointers and fill count; the store needs no clearing.
// The receiver cannot stall: done_o lasts exactly one cycle.

module double_ended_queue import deq_pkg::*; #(
  parameter int CAPACITY = DEQ_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [ActionW-1:0]       action_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     done_o,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] removed_value_o,
  output logic [CountOutW-1:0]     count_o
);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  deq_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .count_o        (count_o)
  );

endmodule

// ===== design/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/deq_ctrl.sv =====
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output deq_cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StResp = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == StIdle);

  // Next state: the action executes in Idle when accepted, the result is reported in Resp
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StResp;
      end
      StResp: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q == StResp);
  assign cmd_o.exec    = accept;
  assign cmd_o.respond = (state_q == StResp);

endmodule

// ===== design/deq_dpath.sv =====
`timescale 1ns / 1ps

module deq_dpath import deq_pkg::*; #(
  parameter int CAPACITY = DEQ_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  deq_cmd_t                 cmd_i,
  input  logic [ActionW-1:0]       action_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     done_o,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] removed_value_o,
  output logic [CountOutW-1:0]     count_o
);

  localparam int PtrW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(CAPACITY - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);

  logic [PtrW-1:0]    left_q, left_d, right_q, right_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               pop_ok_q, pop_ok_d;

  logic [PtrW-1:0] left_up, left_dn, right_up, right_dn;
  logic            is_push, full, empty;
  logic            we, re;
  logic [PtrW-1:0] waddr, raddr;
  logic [ValueW-1:0] rdata;
  logic [CntW+CountOutW-1:0] cnt_ext;

  // Wrapping pointer neighbors
  assign left_up  = (left_q == PtrLast) ? '0 : left_q + 1'b1;
  assign left_dn  = (left_q == '0) ? PtrLast : left_q - 1'b1;
  assign right_up = (right_q == PtrLast) ? '0 : right_q + 1'b1;
  assign right_dn = (right_q == '0) ? PtrLast : right_q - 1'b1;

  assign full  = (cnt_q == CntFull);
  assign empty = (cnt_q == '0);

  // Decode the action and update pointers, count and status
  always_comb begin
    left_d   = left_q;
    right_d  = right_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = right_q;
    raddr    = left_q;
    is_push  = action_i inside {ACT_PUSH_LEFT, ACT_PUSH_RIGHT};
    if (cmd_i.exec) begin
      status_d = STAT_DONE;
      pop_ok_d = 1'b0;
      if (is_push) begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          we    = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (action_i == ACT_PUSH_LEFT) begin
            left_d = left_dn;
            waddr  = left_dn;
          end else begin
            right_d = right_up;
            waddr   = right_q;
          end
        end
      end else begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          re       = 1'b1;
          pop_ok_d = 1'b1;
          cnt_d    = cnt_q - 1'b1;
          if (action_i == ACT_POP_LEFT) begin
            left_d = left_up;
            raddr  = left_q;
          end else begin
            right_d = right_dn;
            raddr   = right_dn;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      cnt_q    <= '0;
      pop_ok_q <= 1'b0;
    end else begin
      left_q   <= left_d;
      right_q  <= right_d;
      cnt_q    <= cnt_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Status is payload, no reset needed
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  deq_ram #(
    .Width(ValueW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Result outputs; count reports the low bits of the fill count
  assign cnt_ext         = (CntW + CountOutW)'(cnt_q);
  assign done_o          = cmd_i.respond;
  assign status_o        = status_q;
  assign removed_value_o = pop_ok_q ? signed'(rdata) : '0;
  assign count_o         = cnt_ext[CountOutW-1:0];

endmodule
